// File: hw/rtl/abba_pkg.sv
`default_nettype none

package abba_pkg;

    // Result field width and the default counter width
    localparam int OUT_W             = 40;
    localparam int COUNT_WIDTH_DEF   = 40;

    // Input and result packing
    localparam int BASE_W            = 8;
    localparam int IN_TDATA_W        = 5 * BASE_W;
    localparam int OUT_FIELDS_W      = 5 * OUT_W + 1;
    localparam int OUT_TDATA_W       = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_INDEX_W       = 1;
    localparam int CFG_DATA_W        = OUT_W;

    // Depth of the classification queue between front and back
    localparam int QUEUE_DEPTH       = 4;

    // Uppercase 'N' marks a missing base
    localparam logic [BASE_W-1:0] CHAR_MISSING = 8'h4E;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LIMIT_ENABLE = 1'b0,
        CFG_BASE_LIMIT   = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic             limit_enable;
        logic [OUT_W-1:0] stop_limit;
    } cfg_t;

    // Site class of one position, as handed from front to back
    typedef struct packed {
        logic abba_hybrid;
        logic baba_hybrid;
        logic abba_ancestral;
        logic baba_ancestral;
        logic last;
    } site_class_t;

endpackage

`default_nettype wire

// File: hw/rtl/abba_front.sv
`default_nettype none

module abba_front
    import abba_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire logic [IN_TDATA_W-1:0] in_bases,
    input  wire logic                  in_last,
    output      logic                  push,
    output      site_class_t           push_data,
    input  wire logic                  queue_full
);

    logic        valid_reg;
    logic        valid_next;
    site_class_t class_reg;
    site_class_t class_next;

    logic [BASE_W-1:0] p2;
    logic [BASE_W-1:0] hy;
    logic [BASE_W-1:0] a1;
    logic [BASE_W-1:0] b1;
    logic [BASE_W-1:0] og;
    logic              clean;
    logic              accept;

    assign p2 = in_bases[0*BASE_W +: BASE_W];
    assign hy = in_bases[1*BASE_W +: BASE_W];
    assign a1 = in_bases[2*BASE_W +: BASE_W];
    assign b1 = in_bases[3*BASE_W +: BASE_W];
    assign og = in_bases[4*BASE_W +: BASE_W];

    assign clean = (p2 != CHAR_MISSING) && (hy != CHAR_MISSING) && (a1 != CHAR_MISSING)
                && (b1 != CHAR_MISSING) && (og != CHAR_MISSING);

    assign push     = valid_reg && !queue_full;
    assign in_ready = !valid_reg || !queue_full;
    assign accept   = in_valid && in_ready;
    assign push_data = class_reg;

    // Classify: pop2 matching outgroup selects ABBA, else pop2 matching pop1b selects BABA
    always_comb begin
        class_next.abba_hybrid    = clean && (p2 == og) && (hy != p2) && (hy == b1);
        class_next.abba_ancestral = clean && (p2 == og) && (b1 != p2) && (a1 == b1);
        class_next.baba_hybrid    = clean && (p2 != og) && (p2 == b1) && (hy != p2)
                                  && (hy == og);
        class_next.baba_ancestral = clean && (p2 != og) && (p2 == b1) && (a1 != p2)
                                  && (a1 == og);
        class_next.last           = in_last;
    end

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            class_reg <= class_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/abba_queue.sv
`default_nettype none

module abba_queue
    import abba_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire site_class_t push_data,
    output      logic        full,
    input  wire logic        pop,
    output      logic        head_valid,
    output      site_class_t head_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    site_class_t      mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/abba_back.sv
`default_nettype none

module abba_back
    import abba_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire cfg_t                   cfg,
    input  wire logic                   head_valid,
    input  wire site_class_t            head_data,
    output      logic                   pop,
    output      logic                   out_valid,
    input  wire logic                   out_ready,
    output      logic [OUT_TDATA_W-1:0] out_data
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam int CMP_W = COUNT_WIDTH + OUT_W;

    logic [COUNT_WIDTH-1:0] ah_reg,   ah_next;
    logic [COUNT_WIDTH-1:0] bh_reg,   bh_next;
    logic [COUNT_WIDTH-1:0] aa_reg,   aa_next;
    logic [COUNT_WIDTH-1:0] ba_reg,   ba_next;
    logic [COUNT_WIDTH-1:0] seq_reg,  seq_next;
    logic [COUNT_WIDTH-1:0] base_reg, base_next;
    logic                   stopped_reg, stopped_next;
    logic                   mvalid_reg,  mvalid_next;
    logic [OUT_TDATA_W-1:0] mdata_reg,   mdata_next;

    logic                   out_free;
    logic                   update;
    logic                   load;
    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH-1:0] base_sum;
    logic [CMP_W-1:0]       base_cmp;
    logic [CMP_W-1:0]       limit_cmp;
    logic                   limit_hit;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        logic [COUNT_WIDTH-1:0] r;
        r = (v == CNT_MAX) ? v : v + COUNT_WIDTH'(1);
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic [COUNT_WIDTH-1:0] v);
        logic [CMP_W-1:0] e;
        e = {{OUT_W{1'b0}}, v};
        return e[OUT_W-1:0];
    endfunction

    // A closing result needs a free output slot; mid-sequence and dropped items do not
    assign out_free = !mvalid_reg || out_ready;
    assign pop      = head_valid && (stopped_reg || !head_data.last || out_free);
    assign update   = pop && !stopped_reg;
    assign load     = update && head_data.last;

    // Base total plus the sequence length (stored count plus this item): add with carry in, then saturate
    assign sum       = {1'b0, base_reg} + {1'b0, seq_reg} + (COUNT_WIDTH+1)'(1);
    assign base_sum  = ((&seq_reg) || sum[COUNT_WIDTH]) ? CNT_MAX : sum[COUNT_WIDTH-1:0];
    assign base_cmp  = {{OUT_W{1'b0}}, base_sum};
    assign limit_cmp = {{COUNT_WIDTH{1'b0}}, cfg.stop_limit};
    assign limit_hit = cfg.limit_enable && (base_cmp >= limit_cmp);

    always_comb begin
        ah_next      = (update && head_data.abba_hybrid)    ? sat_inc(ah_reg) : ah_reg;
        bh_next      = (update && head_data.baba_hybrid)    ? sat_inc(bh_reg) : bh_reg;
        aa_next      = (update && head_data.abba_ancestral) ? sat_inc(aa_reg) : aa_reg;
        ba_next      = (update && head_data.baba_ancestral) ? sat_inc(ba_reg) : ba_reg;
        seq_next     = seq_reg;
        base_next    = base_reg;
        stopped_next = stopped_reg;
        if (update) begin
            seq_next = head_data.last ? '0 : sat_inc(seq_reg);
        end
        if (load) begin
            base_next    = base_sum;
            stopped_next = stopped_reg || limit_hit;
        end
    end

    always_comb begin
        mdata_next = mdata_reg;
        if (load) begin
            mdata_next = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), stopped_next, to_out(base_next),
                          to_out(ba_next), to_out(aa_next), to_out(bh_next), to_out(ah_next)};
        end
        mvalid_next = load ? 1'b1 : (out_ready ? 1'b0 : mvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ah_reg      <= '0;
            bh_reg      <= '0;
            aa_reg      <= '0;
            ba_reg      <= '0;
            seq_reg     <= '0;
            base_reg    <= '0;
            stopped_reg <= 1'b0;
            mvalid_reg  <= 1'b0;
        end else begin
            ah_reg      <= ah_next;
            bh_reg      <= bh_next;
            aa_reg      <= aa_next;
            ba_reg      <= ba_next;
            seq_reg     <= seq_next;
            base_reg    <= base_next;
            stopped_reg <= stopped_next;
            mvalid_reg  <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mdata_reg <= mdata_next;
    end

    assign out_valid = mvalid_reg;
    assign out_data  = mdata_reg;

    // Once stopped, stay stopped until reset
    a_stop_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> stopped_reg)
        else $error("stop flag cleared without reset");

    // Nothing counts while stopped
    a_frozen_when_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> ($stable(ah_reg) && $stable(bh_reg) && $stable(aa_reg)
                        && $stable(ba_reg) && $stable(base_reg)))
        else $error("counters moved while stopped");

    // A result is never overwritten before the receiver takes it
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (mvalid_reg && !out_ready) |-> !load)
        else $error("pending result overwritten");

    // The base total never falls
    a_base_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (base_reg >= $past(base_reg)))
        else $error("base total decreased");

endmodule

`default_nettype wire

// File: hw/rtl/abba_baba_site_counter.sv
// ABBA/BABA site counter.
// Slave stream: one aligned position per transaction, five base bytes in s_tdata and
// s_tlast on the final position of a sequence. Master stream: one transaction per
// sequence end carrying the four site-class totals, the base total and the stop flag.
// A position holding uppercase 'N' in any genome is not classified but still counts
// towards the sequence length. All counters saturate at 2^COUNT_WIDTH - 1.
// Configuration: cfg_wr_en writes cfg_wr_data into register cfg_wr_index at the clock
// edge (0 = limit enable, 1 = base limit); write only while the block is idle.
// Throughput: one position per cycle while the receiver takes results; a closing position
// waits at the queue head while an earlier result is unsent. On its way to m_tvalid it
// passes the front register, the queue and the output register in the back.
// Stall: the front keeps accepting while the four-entry queue has room; the back holds
// a result in its output register and keeps counting mid-sequence positions while the
// receiver stalls, blocking only at the next sequence end.
// Once the base limit stops the block, later transactions are accepted and dropped.
// Reset (aresetn low, synchronous) clears all counters, the stop flag, the queue and
// both configuration registers; no clearing pass is needed.
`default_nettype none

module abba_baba_site_counter
    import abba_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // s_tdata: base_pop2, base_hybrid, base_pop1a, base_pop1b, base_outgroup (8 bits each)
    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   s_tlast,
    // m_tdata: abba_hybrid_count, baba_hybrid_count, abba_ancestral_count,
    // baba_ancestral_count, bases_scanned (40 bits each), limit_reached, zero fill
    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    output      logic [OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic        push;
    site_class_t push_data;
    logic        queue_full;
    logic        pop;
    logic        head_valid;
    site_class_t head_data;

    // Configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_wr_index))
                CFG_LIMIT_ENABLE: cfg_next.limit_enable = cfg_wr_data[0];
                CFG_BASE_LIMIT:   cfg_next.stop_limit   = cfg_wr_data[OUT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accept and classify each position
    abba_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_bases   (s_tdata),
        .in_last    (s_tlast),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    // Queue: decouple classification from counting
    abba_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // Back: advance counters, close sequences, drive results
    abba_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata)
    );

endmodule

`default_nettype wire
